// File: rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Operation and status codes, field widths and the command word that the
// control logic broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    // Request operation codes; the two unused codes are answered as range errors
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5
    } t_op;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // What every cell does in the current cycle
    typedef enum logic [1:0] {
        CK_HOLD   = 2'd0,
        CK_WRITE  = 2'd1,
        CK_INSERT = 2'd2,
        CK_DELETE = 2'd3
    } t_cell_kind;

    // Command word broadcast along the cell row
    typedef struct packed {
        t_cell_kind               kind;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list with positional access
// Push, pop, get, set, insert and delete on up to CAPACITY signed words,
// stored in a row of cells that all shift together.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake         | words
//  ----------+-----------+-------------------+-------------------------------------
//  request   | in        | start, busy       | i_operation, i_position, i_value
//  response  | out       | o_done (strobe)   | o_status, o_read_value, o_element_count
//
//  A request is taken at each edge with start high and busy low; its response
//  shows on the outputs, with o_done high, for the single following cycle.
//  One request per cycle while busy is low: the whole cell row shifts at once for
//  insert or delete, and the read mux over the cells feeds the response register.
//  busy is high only during reset and the cycle after it; the list is empty
//  after reset. The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ple_pkg::OP_W-1:0]          i_operation,
    input  logic [ple_pkg::POS_W-1:0]         i_position,
    input  logic signed [ple_pkg::DATA_W-1:0] i_value,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic signed [ple_pkg::DATA_W-1:0] o_read_value,
    output logic [ple_pkg::COUNT_W-1:0]       o_element_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int MW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    logic                              r_busy;
    logic [CW-1:0]                     r_count;
    logic                              r_done;
    ple_pkg::t_status                  r_status;
    logic signed [ple_pkg::DATA_W-1:0] r_read_value;
    logic [ple_pkg::COUNT_W-1:0]       r_elem_count;

    logic [CW-1:0]                     n_count;
    ple_pkg::t_status                  n_status;
    logic signed [ple_pkg::DATA_W-1:0] n_read_value;

    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    logic [MW-1:0]                     w_pos_x;
    logic [MW-1:0]                     w_cnt_x;
    logic [CW-1:0]                     w_target;
    logic [CW-1:0]                     w_last;
    logic [CW-1:0]                     w_cell_pos;
    ple_pkg::t_cell_cmd                w_cmd;
    logic signed [ple_pkg::DATA_W-1:0] w_cell_data [CAPACITY];

    assign busy     = r_busy | ~i_rst_n;
    assign w_accept = start & ~busy;

    // Position and count compared at a common width
    assign w_pos_x  = MW'(i_position);
    assign w_cnt_x  = MW'(r_count);
    assign w_target = w_pos_x[CW-1:0];
    assign w_last   = r_count - CW'(1);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Request decode: status, read word, new count and the cell command
    always_comb begin
        n_count      = r_count;
        n_status     = ple_pkg::ST_OK;
        n_read_value = '0;
        w_cell_pos   = w_target;
        w_cmd.kind   = ple_pkg::CK_HOLD;
        w_cmd.value  = i_value;
        unique case (ple_pkg::t_op'(i_operation))
            ple_pkg::OP_PUSH: begin
                if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else begin
                    w_cmd.kind = ple_pkg::CK_WRITE;
                    w_cell_pos = r_count;
                    n_count    = r_count + CW'(1);
                end
            end
            ple_pkg::OP_POP: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else begin
                    n_read_value = w_cell_data[w_last[IW-1:0]];
                    n_count      = w_last;
                end
            end
            ple_pkg::OP_GET: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_read_value = w_cell_data[w_target[IW-1:0]];
                end
            end
            ple_pkg::OP_SET: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    w_cmd.kind = ple_pkg::CK_WRITE;
                end
            end
            ple_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    w_cmd.kind = ple_pkg::CK_INSERT;
                    n_count    = r_count + CW'(1);
                end
            end
            ple_pkg::OP_DELETE: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_read_value = w_cell_data[w_target[IW-1:0]];
                    w_cmd.kind   = ple_pkg::CK_DELETE;
                    n_count      = w_last;
                end
            end
            default: n_status = ple_pkg::ST_RANGE;
        endcase
        // cells only move on an accepted word
        if (!w_accept) w_cmd.kind = ple_pkg::CK_HOLD;
    end

    // Row of storage cells, each linked to its neighbors, zero beyond the two ends
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ple_pkg::DATA_W-1:0] w_left;
        logic signed [ple_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end

        ple_cell #(
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_cell_pos),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[g])
        );
    end

    // Control state and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_count      <= '0;
            r_done       <= 1'b0;
            r_elem_count <= '0;
        end else begin
            r_busy <= 1'b0;
            r_done <= w_accept;
            if (w_accept) begin
                r_count      <= n_count;
                r_elem_count <= ple_pkg::COUNT_W'(n_count);
            end
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_value    = r_read_value;
    assign o_element_count = r_elem_count;

endmodule

// File: rtl/core/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list row
// Holds the element at a fixed index. Takes the broadcast value, the word of
// its lower neighbor (insert) or the word of its upper neighbor (delete).
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  logic                              i_clk,
    input  ple_pkg::t_cell_cmd                i_cmd,
    input  logic [CW-1:0]                     i_pos,
    input  logic [CW-1:0]                     i_count,
    input  logic signed [ple_pkg::DATA_W-1:0] i_left,
    input  logic signed [ple_pkg::DATA_W-1:0] i_right,
    output logic signed [ple_pkg::DATA_W-1:0] o_data
);

    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

    logic signed [ple_pkg::DATA_W-1:0] r_data;
    logic signed [ple_pkg::DATA_W-1:0] n_data;

    // Next word of this cell
    always_comb begin
        n_data = r_data;
        unique case (i_cmd.kind)
            ple_pkg::CK_WRITE: begin
                if (IDX == i_pos) n_data = i_cmd.value;
            end
            ple_pkg::CK_INSERT: begin
                // open a gap at the target, later words move up one place
                if (IDX == i_pos) begin
                    n_data = i_cmd.value;
                end else if (IDX > i_pos && IDX <= i_count) begin
                    n_data = i_left;
                end
            end
            ple_pkg::CK_DELETE: begin
                // close the gap, later words move down one place
                if (IDX >= i_pos && IDX_NEXT < i_count) n_data = i_right;
            end
            default: n_data = r_data;
        endcase
    end

    // Element word, no reset: only entries below the count are ever read
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/ple_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker: port-level checks of the positional list engine
// Response timing and consistency of status, read word and element count.
// ----------------------------------------------------------------------------
module ple_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_done,
    input logic [1:0]                        o_status,
    input logic signed [ple_pkg::DATA_W-1:0] o_read_value,
    input logic [ple_pkg::COUNT_W-1:0]       o_element_count
);

    // Every taken request answers in the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("request taken without a response");

    // No response without a request
    a_no_stray_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("response without a request");

    // A failed request leaves the count as it was
    a_err_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ple_pkg::ST_OK)
            |-> (o_element_count == $past(o_element_count)))
        else $error("failed request changed the count");

    // A failed request reads nothing
    a_err_zero_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ple_pkg::ST_OK) |-> (o_read_value == '0))
        else $error("failed request returned a word");

    // Empty status only on an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ple_pkg::ST_EMPTY) |-> (o_element_count == '0))
        else $error("empty status with elements held");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_read_value    (o_read_value),
    .o_element_count (o_element_count)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional list engine
// A short table of directed requests covers the empty list, the full list,
// the word extremes and the unused operation codes. A long stream of random
// requests follows, drifting the list between empty and full. A behavioral
// list model predicts each response word that the table does not fix, and a
// monitor checks each o_done strobe against the oldest expected word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIST_DEPTH    = 16;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 50;

    // Operation codes with no meaning; the block answers them as range errors
    localparam logic [ple_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [ple_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    // One response word
    typedef struct packed {
        logic [1:0]                  status;
        logic [ple_pkg::DATA_W-1:0]  read_value;
        logic [ple_pkg::COUNT_W-1:0] count;
    } t_list_reply;

    // One row of the directed table
    typedef struct packed {
        logic [ple_pkg::OP_W-1:0]   op;
        logic [ple_pkg::POS_W-1:0]  pos;
        logic [ple_pkg::DATA_W-1:0] val;
        int                         reps;
        bit                         fixed;
        t_list_reply                reply;
    } t_request_row;

    logic                               i_clk           = 1'b0;
    logic                               i_rst_n         = 1'b0;
    logic                               start           = 1'b0;
    logic [ple_pkg::OP_W-1:0]           i_operation     = '0;
    logic [ple_pkg::POS_W-1:0]          i_position      = '0;
    logic signed [ple_pkg::DATA_W-1:0]  i_value         = '0;
    logic                               busy;
    logic                               o_done;
    logic [1:0]                         o_status;
    logic signed [ple_pkg::DATA_W-1:0]  o_read_value;
    logic [ple_pkg::COUNT_W-1:0]        o_element_count;

    // List model state
    logic [ple_pkg::DATA_W-1:0] list_cells [LIST_DEPTH];
    int                         list_len = 0;

    t_list_reply                reply_queue [$];
    t_request_row               request_table [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int words_checked  = 0;
    int idle_cycles    = 0;
    int peak_len       = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    positional_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_read_value   (o_read_value),
        .o_element_count(o_element_count)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the list model and return the response it gives
    function t_list_reply apply_list_request(input logic [ple_pkg::OP_W-1:0] op,
                                             input logic [ple_pkg::POS_W-1:0] pos,
                                             input logic [ple_pkg::DATA_W-1:0] val);
        t_list_reply r;
        int          p;
        int          k;
        r.status     = ple_pkg::ST_OK;
        r.read_value = '0;
        p = int'(pos);
        case (op)
            ple_pkg::OP_PUSH: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ple_pkg::ST_FULL;
                end else begin
                    list_cells[list_len] = val;
                    list_len++;
                end
            end
            ple_pkg::OP_POP: begin
                if (list_len == 0) begin
                    r.status = ple_pkg::ST_EMPTY;
                end else begin
                    r.read_value = list_cells[list_len-1];
                    list_len--;
                end
            end
            ple_pkg::OP_GET, ple_pkg::OP_SET, ple_pkg::OP_DELETE: begin
                if (list_len == 0) begin
                    r.status = ple_pkg::ST_EMPTY;
                end else if (p >= list_len) begin
                    r.status = ple_pkg::ST_RANGE;
                end else if (op == ple_pkg::OP_GET) begin
                    r.read_value = list_cells[p];
                end else if (op == ple_pkg::OP_SET) begin
                    list_cells[p] = val;
                end else begin
                    r.read_value = list_cells[p];
                    for (k = p; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k+1];
                    list_len--;
                end
            end
            ple_pkg::OP_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ple_pkg::ST_FULL;
                end else if (p > list_len) begin
                    r.status = ple_pkg::ST_RANGE;
                end else begin
                    for (k = list_len; k > p; k--)
                        list_cells[k] = list_cells[k-1];
                    list_cells[p] = val;
                    list_len++;
                end
            end
            default: r.status = ple_pkg::ST_RANGE;
        endcase
        r.count = list_len[ple_pkg::COUNT_W-1:0];
        if (list_len > peak_len)
            peak_len = list_len;
        return r;
    endfunction

    // Print one mismatch line (first few only) and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH %s: got %0h want %0h (word %0d)", what, got, want,
                     words_checked);
        mismatch_count++;
    endtask

    // Hand one request to the block, record its prediction, then maybe idle
    task automatic send_word(input logic [ple_pkg::OP_W-1:0] op,
                             input logic [ple_pkg::POS_W-1:0] pos,
                             input logic [ple_pkg::DATA_W-1:0] val, input bit fixed,
                             input t_list_reply fixed_reply, input bit quiet);
        t_list_reply predicted;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = apply_list_request(op, pos, val);
        reply_queue.push_back(fixed ? fixed_reply : predicted);
        items_sent++;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 29) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Hold the sender off until every outstanding word is back
    task automatic drain_replies();
        start <= 1'b0;
        while (reply_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_row(input logic [ple_pkg::OP_W-1:0] op,
                           input logic [ple_pkg::POS_W-1:0] pos,
                           input logic [ple_pkg::DATA_W-1:0] val, input int reps,
                           input bit fixed, input logic [1:0] st,
                           input logic [ple_pkg::DATA_W-1:0] rd,
                           input logic [ple_pkg::COUNT_W-1:0] cnt);
        t_request_row row;
        row.op               = op;
        row.pos              = pos;
        row.val              = val;
        row.reps             = reps;
        row.fixed            = fixed;
        row.reply.status     = st;
        row.reply.read_value = rd;
        row.reply.count      = cnt;
        request_table.push_back(row);
    endtask

    // Response checker and stall watchdog
    always @(posedge i_clk) begin
        t_list_reply want;
        if (i_rst_n && o_done) begin
            if (reply_queue.size() == 0) begin
                report_mismatch("response with nothing expected", 32'(o_status), 0);
            end else begin
                want = reply_queue.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", o_read_value, want.read_value);
                if (o_element_count !== want.count)
                    report_mismatch("element_count", 32'(o_element_count),
                                    32'(want.count));
                status_tally[want.status]++;
                words_checked++;
            end
        end
        if ((i_rst_n && start && !busy) || o_done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_request_row               row;
        t_list_reply                none;
        logic [ple_pkg::OP_W-1:0]   op;
        logic [ple_pkg::POS_W-1:0]  pos;
        logic [ple_pkg::DATA_W-1:0] val;
        bit                         growing;
        int                         roll;
        int                         n;
        int                         r;

        none    = '0;
        growing = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty list, extremes, full list, unused codes
        add_row(ple_pkg::OP_POP, 0, 32'h0, 1, 1, ple_pkg::ST_EMPTY, 32'h0, 0);
        add_row(ple_pkg::OP_GET, 0, 32'h0, 1, 1, ple_pkg::ST_EMPTY, 32'h0, 0);
        add_row(ple_pkg::OP_SET, 3, 32'h1234_5678, 1, 1, ple_pkg::ST_EMPTY, 32'h0, 0);
        add_row(ple_pkg::OP_DELETE, 0, 32'h0, 1, 1, ple_pkg::ST_EMPTY, 32'h0, 0);
        add_row(ple_pkg::OP_INSERT, 1, 32'h1, 1, 1, ple_pkg::ST_RANGE, 32'h0, 0);
        add_row(OP_SPARE_6, 0, 32'hFFFF_FFFF, 1, 1, ple_pkg::ST_RANGE, 32'h0, 0);
        add_row(ple_pkg::OP_PUSH, 31, 32'h8000_0000, 1, 1, ple_pkg::ST_OK, 32'h0, 1);
        add_row(ple_pkg::OP_POP, 0, 32'h0, 1, 1, ple_pkg::ST_OK, 32'h8000_0000, 0);
        add_row(ple_pkg::OP_INSERT, 0, 32'h7FFF_FFFF, 1, 1, ple_pkg::ST_OK, 32'h0, 1);
        add_row(ple_pkg::OP_GET, 0, 32'h0, 1, 1, ple_pkg::ST_OK, 32'h7FFF_FFFF, 1);
        add_row(ple_pkg::OP_GET, 1, 32'h0, 1, 1, ple_pkg::ST_RANGE, 32'h0, 1);
        add_row(ple_pkg::OP_GET, 31, 32'h0, 1, 1, ple_pkg::ST_RANGE, 32'h0, 1);
        add_row(ple_pkg::OP_INSERT, 0, 32'hFFFF_FFFF, 1, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(ple_pkg::OP_INSERT, 2, 32'h0, 1, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(ple_pkg::OP_SET, 1, 32'h5555_5555, 1, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(ple_pkg::OP_PUSH, 0, 32'h0BAD_0000, 13, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(ple_pkg::OP_PUSH, 0, 32'h1, 1, 1, ple_pkg::ST_FULL, 32'h0, 16);
        add_row(ple_pkg::OP_INSERT, 31, 32'h2, 1, 1, ple_pkg::ST_FULL, 32'h0, 16);
        add_row(ple_pkg::OP_INSERT, 0, 32'h3, 1, 1, ple_pkg::ST_FULL, 32'h0, 16);
        add_row(ple_pkg::OP_GET, 15, 32'h0, 1, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(ple_pkg::OP_GET, 16, 32'h0, 1, 1, ple_pkg::ST_RANGE, 32'h0, 16);
        add_row(ple_pkg::OP_DELETE, 0, 32'h0, 1, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(ple_pkg::OP_DELETE, 14, 32'h0, 1, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(ple_pkg::OP_DELETE, 14, 32'h0, 1, 1, ple_pkg::ST_RANGE, 32'h0, 14);
        add_row(ple_pkg::OP_SET, 13, 32'hAAAA_AAAA, 1, 0, ple_pkg::ST_OK, 32'h0, 0);
        add_row(OP_SPARE_7, 5, 32'h0, 1, 1, ple_pkg::ST_RANGE, 32'h0, 14);

        while (request_table.size() != 0) begin
            row = request_table.pop_front();
            for (r = 0; r < row.reps; r++)
                send_word(row.op, row.pos, row.val + r, row.fixed, row.reply, 1'b0);
        end
        drain_replies();

        // Random requests; the list drifts between empty and full
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 500 == 499)
                drain_replies();
            if (list_len == LIST_DEPTH)
                growing = 1'b0;
            else if (list_len == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 63) == 0)
                growing = ~growing;

            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            else if (growing)
                op = roll < 30 ? ple_pkg::OP_PUSH : roll < 55 ? ple_pkg::OP_INSERT :
                     roll < 68 ? ple_pkg::OP_GET : roll < 80 ? ple_pkg::OP_SET :
                     roll < 90 ? ple_pkg::OP_POP : ple_pkg::OP_DELETE;
            else
                op = roll < 12 ? ple_pkg::OP_PUSH : roll < 22 ? ple_pkg::OP_INSERT :
                     roll < 35 ? ple_pkg::OP_GET : roll < 47 ? ple_pkg::OP_SET :
                     roll < 70 ? ple_pkg::OP_POP : ple_pkg::OP_DELETE;

            // Mostly legal positions, some anywhere in the field
            if ($urandom_range(0, 9) == 0)
                pos = ple_pkg::POS_W'($urandom_range(0, 31));
            else if (op == ple_pkg::OP_INSERT)
                pos = ple_pkg::POS_W'($urandom_range(0, list_len));
            else
                pos = (list_len == 0) ? '0 :
                      ple_pkg::POS_W'($urandom_range(0, list_len - 1));

            case ($urandom_range(0, 7))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'h0;
                3:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase

            // One long run with the sender never idling
            send_word(op, pos, val, 1'b0, none, (n >= 600 && n < 900));
        end

        // Let the last words come back, then a short tail
        start <= 1'b0;
        for (r = 0; r < 50 && reply_queue.size() != 0; r++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (reply_queue.size() != 0)
            report_mismatch("words never returned", reply_queue.size(), 0);

        $display("run: %0d requests sent, %0d responses checked, peak length %0d",
                 items_sent, words_checked, peak_len);
        $display("status mix: ok %0d, range %0d, full %0d, empty %0d",
                 status_tally[ple_pkg::ST_OK], status_tally[ple_pkg::ST_RANGE],
                 status_tally[ple_pkg::ST_FULL], status_tally[ple_pkg::ST_EMPTY]);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
